[rtl/qws_pkg.sv]
`timescale 1ns / 1ps

package qws_pkg;

  // Result kinds.
  localparam logic [2:0] KIND_BYTE     = 3'd0;
  localparam logic [2:0] KIND_WORD_END = 3'd1;
  localparam logic [2:0] KIND_DONE     = 3'd2;
  localparam logic [2:0] KIND_SYNTAX   = 3'd3;
  localparam logic [2:0] KIND_TOO_MANY = 3'd4;

  // Special characters.
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_END    = 8'h00;

  // Quote modes.
  localparam logic [1:0] QM_OUTSIDE = 2'd0;
  localparam logic [1:0] QM_DOUBLE  = 2'd1;
  localparam logic [1:0] QM_SINGLE  = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_KEEP_QUOTES = 1'b0;
  localparam logic CFG_MAX_WORDS   = 1'b1;

  localparam logic [15:0] MAX_WORDS_RESET = 16'd1024;

  // Parser state carried from one byte to the next.
  typedef struct packed {
    logic [1:0]  quote_mode;
    logic        escape_pending;
    logic        word_nonempty;
    logic [15:0] slot_count;
    logic        discarding;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    quote_mode:     QM_OUTSIDE,
    escape_pending: 1'b0,
    word_nonempty:  1'b0,
    slot_count:     16'd1,
    discarding:     1'b0
  };

  // One result item.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       last;
  } result_t;

  // All results caused by one byte: zero, one or two of them.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } step_out_t;

endpackage

[rtl/quoted_word_splitter.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  ch
// output    out        out_valid/ out_stall kind, out_byte, last
// config    in         cfg_we               cfg_index, cfg_data
//
// A byte is registered on acceptance and decoded from that register, which
// pushes zero, one or two results into a four-entry result queue.
// One byte is taken per cycle while the queue has room for two results;
// the output delivers one result per cycle while out_stall is low, so bytes
// that give two results limit the sustained rate to the output side.
// Reset (rst, synchronous) clears the parser state, the queue and the
// configuration registers to keep_quotes = 0 and max_words = 1024.

module quoted_word_splitter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  ch,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [7:0]  out_byte,
  output logic        last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int QDEPTH = 4;
  localparam int PW     = $clog2(QDEPTH);

  logic                  keep_quotes;
  logic [15:0]           max_words;
  logic                  byte_valid;
  logic [7:0]            byte_reg;
  qws_pkg::parse_state_t state;
  qws_pkg::parse_state_t state_next;
  qws_pkg::step_out_t    step;
  qws_pkg::result_t      queue [QDEPTH];
  logic [PW-1:0]         wr_ptr;
  logic [PW-1:0]         rd_ptr;
  logic [PW:0]           count;
  logic [PW:0]           count_next;
  logic                  room;
  logic                  fire;
  logic                  pop;
  logic [PW:0]           push_count;
  qws_pkg::result_t      head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_quotes <= 1'b0;
      max_words   <= qws_pkg::MAX_WORDS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        qws_pkg::CFG_KEEP_QUOTES: keep_quotes <= cfg_data[0];
        qws_pkg::CFG_MAX_WORDS:   max_words   <= cfg_data;
        default:                  keep_quotes <= keep_quotes;
      endcase
    end
  end

  // The registered byte is decoded when the queue can hold two results.
  assign room     = count <= (PW+1)'(QDEPTH - 2);
  assign fire     = byte_valid && room;
  assign in_stall = byte_valid && !room;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!in_stall) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_reg <= ch;
    end
  end

  qws_decode u_decode (
    .state       (state),
    .ch          (byte_reg),
    .keep_quotes (keep_quotes),
    .max_words   (max_words),
    .state_next  (state_next),
    .step        (step)
  );

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qws_pkg::STATE_RESET;
    end else if (fire) begin
      state <= state_next;
    end
  end

  // Result queue.
  assign push_count = fire ? (PW+1)'(step.count) : '0;
  assign pop        = out_valid && !out_stall;
  assign count_next = count + push_count - (PW+1)'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_count[PW-1:0];
      rd_ptr <= rd_ptr + PW'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (step.count != 2'd0)) begin
      queue[wr_ptr] <= step.first;
    end
    if (fire && (step.count == 2'd2)) begin
      queue[wr_ptr + PW'(1)] <= step.second;
    end
  end

  // Output transaction comes from the head of the queue.
  assign head      = queue[rd_ptr];
  assign out_valid = count != '0;
  assign kind      = head.kind;
  assign out_byte  = head.data;
  assign last      = head.last;

endmodule

[rtl/qws_decode.sv]
`timescale 1ns / 1ps

module qws_decode (
  input  qws_pkg::parse_state_t state,
  input  logic [7:0]            ch,
  input  logic                  keep_quotes,
  input  logic [15:0]           max_words,
  output qws_pkg::parse_state_t state_next,
  output qws_pkg::step_out_t    step
);

  logic          quote_match;
  logic          close_err;
  qws_pkg::result_t close_res;
  qws_pkg::parse_state_t close_state;

  // The byte matches the quote that opened the current span.
  assign quote_match = ((state.quote_mode == qws_pkg::QM_DOUBLE) && (ch == qws_pkg::CH_DQUOTE))
                    || ((state.quote_mode == qws_pkg::QM_SINGLE) && (ch == qws_pkg::CH_SQUOTE));

  // Closing a word fails once the next slot would reach the limit.
  assign close_err = ({1'b0, state.slot_count} + 17'd1) >= {1'b0, max_words};

  // Result and state when a word closes; the caller fixes up quote_mode.
  always_comb begin
    close_res   = '0;
    close_state = state;
    if (close_err) begin
      close_res.kind         = qws_pkg::KIND_TOO_MANY;
      close_state            = qws_pkg::STATE_RESET;
      close_state.discarding = 1'b1;
    end else begin
      close_res.kind            = qws_pkg::KIND_WORD_END;
      close_state.slot_count    = state.slot_count + 16'd1;
      close_state.word_nonempty = 1'b0;
    end
  end

  // Next state and results for one byte.
  always_comb begin
    state_next = state;
    step       = '0;
    if (state.discarding) begin
      if (ch == qws_pkg::CH_END) begin
        state_next.discarding = 1'b0;
      end
    end else if (state.escape_pending) begin
      state_next.escape_pending = 1'b0;
      if (ch == qws_pkg::CH_END) begin
        step.count      = 2'd1;
        step.first.kind = qws_pkg::KIND_SYNTAX;
        state_next      = qws_pkg::STATE_RESET;
      end else if ((quote_match || (ch == qws_pkg::CH_BSLASH)) && !keep_quotes) begin
        step.count               = 2'd1;
        step.first.kind          = qws_pkg::KIND_BYTE;
        step.first.data          = ch;
        state_next.word_nonempty = 1'b1;
      end else begin
        step.count               = 2'd2;
        step.first.kind          = qws_pkg::KIND_BYTE;
        step.first.data          = qws_pkg::CH_BSLASH;
        step.second.kind         = qws_pkg::KIND_BYTE;
        step.second.data         = ch;
        state_next.word_nonempty = 1'b1;
      end
    end else if ((ch == qws_pkg::CH_DQUOTE) || (ch == qws_pkg::CH_SQUOTE)) begin
      if (state.quote_mode == qws_pkg::QM_OUTSIDE) begin
        state_next.quote_mode = (ch == qws_pkg::CH_DQUOTE) ? qws_pkg::QM_DOUBLE
                                                           : qws_pkg::QM_SINGLE;
        if (keep_quotes) begin
          step.count               = 2'd1;
          step.first.kind          = qws_pkg::KIND_BYTE;
          step.first.data          = ch;
          state_next.word_nonempty = 1'b1;
        end
      end else if (quote_match) begin
        if (keep_quotes) begin
          step.count      = 2'd2;
          step.first.kind = qws_pkg::KIND_BYTE;
          step.first.data = ch;
          step.second     = close_res;
          state_next      = close_state;
          state_next.quote_mode = qws_pkg::QM_OUTSIDE;
        end else if (state.word_nonempty) begin
          step.count  = 2'd1;
          step.first  = close_res;
          state_next  = close_state;
          state_next.quote_mode = qws_pkg::QM_OUTSIDE;
        end else begin
          state_next.quote_mode = qws_pkg::QM_OUTSIDE;
        end
      end else begin
        step.count               = 2'd1;
        step.first.kind          = qws_pkg::KIND_BYTE;
        step.first.data          = ch;
        state_next.word_nonempty = 1'b1;
      end
    end else if (ch == qws_pkg::CH_BSLASH) begin
      state_next.escape_pending = 1'b1;
    end else if (ch == qws_pkg::CH_SPACE) begin
      if (state.quote_mode != qws_pkg::QM_OUTSIDE) begin
        step.count               = 2'd1;
        step.first.kind          = qws_pkg::KIND_BYTE;
        step.first.data          = ch;
        state_next.word_nonempty = 1'b1;
      end else if (state.word_nonempty) begin
        step.count = 2'd1;
        step.first = close_res;
        state_next = close_state;
      end
    end else if (ch == qws_pkg::CH_END) begin
      step.count      = 2'd1;
      step.first.kind = (state.quote_mode != qws_pkg::QM_OUTSIDE) ? qws_pkg::KIND_SYNTAX
                                                                  : qws_pkg::KIND_DONE;
      state_next      = qws_pkg::STATE_RESET;
    end else begin
      step.count               = 2'd1;
      step.first.kind          = qws_pkg::KIND_BYTE;
      step.first.data          = ch;
      state_next.word_nonempty = 1'b1;
    end

    // Mark the final result of this byte.
    if (step.count == 2'd1) begin
      step.first.last = 1'b1;
    end else if (step.count == 2'd2) begin
      step.second.last = 1'b1;
    end
  end

endmodule
